[sv/tga_pixel_stream_decoder_unit_defines.svh]
// Assertion macros shared by the decoder's checker.
`ifndef TGA_PIXEL_STREAM_DECODER_UNIT_DEFINES_SVH
`define TGA_PIXEL_STREAM_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define TGAD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define TGAD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset
`define TGAD_ASSERT_NXT_NR(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tgad_pkg.sv]
// Types, constants and pixel unpacking functions of the TGA pixel decoder.
package tgad_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_IMAGE_KIND      = 3'd0;
    localparam logic [2:0] CFG_PIXEL_BYTES     = 3'd1;
    localparam logic [2:0] CFG_MAP_ENTRY_BYTES = 3'd2;
    localparam logic [2:0] CFG_PIXEL_COUNT     = 3'd3;

    // Register reset values
    localparam logic [1:0]  RST_IMAGE_KIND      = 2'd1;
    localparam logic [2:0]  RST_PIXEL_BYTES     = 3'd4;
    localparam logic [2:0]  RST_MAP_ENTRY_BYTES = 3'd3;
    localparam logic [24:0] RST_PIXEL_COUNT     = 25'd65536;

    // Request types
    localparam logic REQ_MAP_LOAD  = 1'b0;
    localparam logic REQ_DATA_BYTE = 1'b1;

    // image_kind bits: bit 0 clear means colour-mapped, bit 1 set means run-length
    localparam int KIND_TRUECOLOR_BIT = 0;
    localparam int KIND_RLE_BIT       = 1;

    // Pixel waiting for its colour-map read or for unpacking
    typedef struct packed {
        logic        mapped;
        logic        zero_entry;
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic [7:0]  repeat_count;
        logic        last;
    } t_s1;

    function automatic logic [2:0] clamp_bytes(input logic [2:0] n);
        logic [2:0] r;
        if (n < 3'd2) r = 3'd2;
        else if (n > 3'd4) r = 3'd4;
        else r = n;
        return r;
    endfunction

    function automatic logic [7:0] widen5(input logic [4:0] x);
        return {x, x[4:2]};
    endfunction

    // Raw little-endian word to ARGB; n already clamped to 2..4
    function automatic logic [31:0] unpack_word(input logic [31:0] w, input logic [2:0] n);
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [4:0]  r5;
        logic [4:0]  g5;
        logic [4:0]  b5;
        logic [31:0] res;
        lo = w[7:0];
        hi = w[15:8];
        r5 = hi[6:2];
        g5 = {hi[1:0], lo[7:5]};
        b5 = lo[4:0];
        if (n == 3'd2) begin
            res = {{8{hi[7]}}, widen5(r5), widen5(g5), widen5(b5)};
        end else if (n == 3'd3) begin
            res = {8'hFF, w[23:0]};
        end else begin
            res = w;
        end
        return res;
    endfunction

endpackage

[sv/tgad_in_if.sv]
// Input request channel: colour-map loads and image data bytes.
interface tgad_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  map_index;
    logic [31:0] map_entry;
    logic [7:0]  data_byte;

    modport source (output valid, req_type, map_index, map_entry, data_byte, input ready);
    modport sink   (input valid, req_type, map_index, map_entry, data_byte, output ready);
endinterface

[sv/tgad_out_if.sv]
// Result channel: one ARGB pixel with its repeat count.
interface tgad_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_argb;
    logic [7:0]  repeat_count;
    logic        last_of_image;

    modport source (output valid, pixel_argb, repeat_count, last_of_image, input ready);
    modport sink   (input valid, pixel_argb, repeat_count, last_of_image, output ready);
endinterface

[sv/tgad_cfg_if.sv]
// Configuration write channel: register index and write data.
interface tgad_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[sv/tga_pixel_stream_decoder_unit.sv]
// TGA pixel stream decoder: top level with colour-map RAM and two-stage pipeline.
//
// Use: i_cfg writes image_kind, pixel_bytes, map_entry_bytes and pixel_count
// (indexes 0..3) while the block is idle; a write to any of them restarts the
// image, other indexes are ignored.
// i_pix carries requests: req_type 0 loads a colour-map entry, req_type 1
// delivers one image data byte. o_res gives one ARGB pixel with a repeat
// count and a flag on the last pixel of the image; after it the next image
// starts with the pixel counter reloaded.
// Throughput: one request per cycle, sustained, as long as o_res is taken.
// Path: a byte that completes a pixel is accepted at the edge where the
// colour-map read and the stage register load; the unpacked result is then
// registered in the output register when the stage advances, and o_res gives it.
// Loads, packet headers and partial truecolor bytes give no result.
// Reset: control state clears and the registers take their reset values;
// the colour map is not cleared and holds nothing defined until loaded.
// Stall: while o_res is held, one more completed pixel waits in the
// pipeline stage and i_pix.ready drops once that stage is full.
module tga_pixel_stream_decoder_unit #(
    parameter int MAP_ENTRIES = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tgad_cfg_if.sink   i_cfg,
    tgad_in_if.sink    i_pix,
    tgad_out_if.source o_res
);
    import tgad_pkg::*;

    localparam int AW = $clog2(MAP_ENTRIES);

    // Configuration registers
    logic [1:0]  r_image_kind;
    logic [2:0]  r_pixel_bytes;
    logic [2:0]  r_map_entry_bytes;
    logic [24:0] r_pixel_count;
    logic [1:0]  n_image_kind;
    logic [2:0]  n_pixel_bytes;
    logic [2:0]  n_map_entry_bytes;
    logic [24:0] n_pixel_count;

    // Decode state
    logic [23:0] r_gather,   n_gather;
    logic [1:0]  r_pos,      n_pos;
    logic [7:0]  r_pkt_rem,  n_pkt_rem;
    logic        r_pkt_run,  n_pkt_run;
    logic [24:0] r_left,     n_left;

    // Pipeline stage and output register
    logic        r_s1_valid, n_s1_valid;
    t_s1         r_s1,       n_s1;
    logic        r_out_valid;
    logic [31:0] r_out_argb;
    logic [7:0]  r_out_count;
    logic        r_out_last;

    logic        cfg_acc;
    logic        cfg_hit;
    logic        pix_acc;
    logic        s1_adv;
    logic        s1_load;
    logic        ram_we;
    logic        ram_re;
    logic [31:0] ram_rdata;
    logic [31:0] s2_word;

    logic        mapped;
    logic        rle;
    logic [2:0]  need;
    logic [7:0]  len;
    logic [7:0]  rep;
    logic [24:0] left_after;
    logic [24:0] restart_count;

    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid;
    // only writes to a listed register restart the image
    assign cfg_hit     = cfg_acc && (i_cfg.index <= CFG_PIXEL_COUNT);

    assign s1_adv      = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign pix_acc     = i_pix.valid && i_pix.ready;

    assign mapped = !r_image_kind[KIND_TRUECOLOR_BIT];
    assign rle    = r_image_kind[KIND_RLE_BIT];
    assign need   = clamp_bytes(r_pixel_bytes);

    // Colour-map writes; indexes beyond the store are dropped
    assign ram_we = pix_acc && (i_pix.req_type == REQ_MAP_LOAD)
                    && ({1'b0, i_pix.map_index} < 9'(MAP_ENTRIES));

    tgad_ram #(
        .WIDTH (32),
        .DEPTH (MAP_ENTRIES)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_pix.map_index[AW-1:0]),
        .i_wdata (i_pix.map_entry),
        .i_re    (ram_re),
        .i_raddr (i_pix.data_byte[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Configuration register writes
    always_comb begin
        n_image_kind      = r_image_kind;
        n_pixel_bytes     = r_pixel_bytes;
        n_map_entry_bytes = r_map_entry_bytes;
        n_pixel_count     = r_pixel_count;
        if (cfg_acc) begin
            unique case (i_cfg.index)
                CFG_IMAGE_KIND:      n_image_kind      = i_cfg.data[1:0];
                CFG_PIXEL_BYTES:     n_pixel_bytes     = i_cfg.data[2:0];
                CFG_MAP_ENTRY_BYTES: n_map_entry_bytes = i_cfg.data[2:0];
                CFG_PIXEL_COUNT:     n_pixel_count     = i_cfg.data[24:0];
                default: ;
            endcase
        end
    end

    assign restart_count = (n_pixel_count == 25'd0) ? 25'd1 : n_pixel_count;

    // Byte decode: packet headers, truecolor gathering, pixel completion
    always_comb begin
        n_gather   = r_gather;
        n_pos      = r_pos;
        n_pkt_rem  = r_pkt_rem;
        n_pkt_run  = r_pkt_run;
        n_left     = r_left;
        n_s1       = r_s1;
        s1_load    = 1'b0;
        ram_re     = 1'b0;
        len        = {1'b0, i_pix.data_byte[6:0]} + 8'd1;
        rep        = 8'd1;
        left_after = r_left;

        if (pix_acc && (i_pix.req_type == REQ_DATA_BYTE)) begin
            if (rle && (r_pkt_rem == 8'd0)) begin
                // packet header
                if (25'(len) > r_left) len = r_left[7:0];
                n_pkt_rem = len;
                n_pkt_run = i_pix.data_byte[7];
                n_gather  = 24'd0;
                n_pos     = 2'd0;
            end else if (!mapped && (({1'b0, r_pos} + 3'd1) < need)) begin
                // more truecolor bytes to come
                n_gather = 24'(({8'd0, r_gather})
                               | (32'(i_pix.data_byte) << {r_pos, 3'b000}));
                n_pos    = r_pos + 2'd1;
            end else begin
                // pixel complete
                s1_load         = 1'b1;
                n_s1.mapped     = mapped;
                n_s1.zero_entry = !({1'b0, i_pix.data_byte} < 9'(MAP_ENTRIES));
                n_s1.word       = {8'd0, r_gather} | (32'(i_pix.data_byte) << {r_pos, 3'b000});
                n_s1.nbytes     = mapped ? clamp_bytes(r_map_entry_bytes) : need;
                ram_re          = mapped && !n_s1.zero_entry;
                if (!mapped) begin
                    n_gather = 24'd0;
                    n_pos    = 2'd0;
                end
                if (rle && r_pkt_run) begin
                    rep       = r_pkt_rem;
                    n_pkt_rem = 8'd0;
                end else if (rle) begin
                    n_pkt_rem = r_pkt_rem - 8'd1;
                end
                if (25'(rep) > r_left) rep = r_left[7:0];
                if (rep == 8'd0) rep = 8'd1;
                left_after        = r_left - 25'(rep);
                n_left            = left_after;
                n_s1.repeat_count = rep;
                n_s1.last         = (left_after == 25'd0);
                if (left_after == 25'd0) begin
                    // image end: start the next one
                    n_gather  = 24'd0;
                    n_pos     = 2'd0;
                    n_pkt_rem = 8'd0;
                    n_pkt_run = 1'b0;
                    n_left    = restart_count;
                end
            end
        end

        // a write to a listed register restarts the image
        if (cfg_hit) begin
            n_gather  = 24'd0;
            n_pos     = 2'd0;
            n_pkt_rem = 8'd0;
            n_pkt_run = 1'b0;
            n_left    = restart_count;
        end
    end

    always_comb begin
        if (s1_load) n_s1_valid = 1'b1;
        else if (s1_adv) n_s1_valid = 1'b0;
        else n_s1_valid = r_s1_valid;
    end

    // Second stage: pick RAM data or gathered word, unpack
    assign s2_word = r_s1.mapped ? (r_s1.zero_entry ? 32'd0 : ram_rdata) : r_s1.word;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_kind      <= RST_IMAGE_KIND;
            r_pixel_bytes     <= RST_PIXEL_BYTES;
            r_map_entry_bytes <= RST_MAP_ENTRY_BYTES;
            r_pixel_count     <= RST_PIXEL_COUNT;
            r_gather          <= 24'd0;
            r_pos             <= 2'd0;
            r_pkt_rem         <= 8'd0;
            r_pkt_run         <= 1'b0;
            r_left            <= RST_PIXEL_COUNT;
            r_s1_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            r_image_kind      <= n_image_kind;
            r_pixel_bytes     <= n_pixel_bytes;
            r_map_entry_bytes <= n_map_entry_bytes;
            r_pixel_count     <= n_pixel_count;
            r_gather          <= n_gather;
            r_pos             <= n_pos;
            r_pkt_rem         <= n_pkt_rem;
            r_pkt_run         <= n_pkt_run;
            r_left            <= n_left;
            r_s1_valid        <= n_s1_valid;
            if (s1_adv) r_out_valid <= 1'b1;
            else if (o_res.ready) r_out_valid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_out_argb  <= unpack_word(s2_word, r_s1.nbytes);
            r_out_count <= r_s1.repeat_count;
            r_out_last  <= r_s1.last;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.pixel_argb    = r_out_argb;
    assign o_res.repeat_count  = r_out_count;
    assign o_res.last_of_image = r_out_last;
endmodule

[sv/tgad_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tgad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[sv/tgad_checker.sv]
// Port-level checks on the decoder's result channel, bound to the top level.
`include "tga_pixel_stream_decoder_unit_defines.svh"

module tgad_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [31:0] i_res_argb,
    input logic [7:0]  i_res_count,
    input logic        i_res_last
);
    // repeat count always within one packet's reach
    `TGAD_ASSERT_IMP(a_count_range, i_clk, i_rst_n, i_res_valid, (i_res_count != 8'd0) && (i_res_count <= 8'd128), "repeat count out of range")

    // no result straight after reset
    `TGAD_ASSERT_NXT_NR(a_reset_empty, i_clk, !i_rst_n, !i_res_valid, "result valid after reset")

    // a stalled result is held
    `TGAD_ASSERT_NXT(a_hold_valid, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid, "result dropped while stalled")

    // its payload does not move
    `TGAD_ASSERT_NXT(a_hold_data, i_clk, i_rst_n, i_res_valid && !i_res_ready, $stable(i_res_argb) && $stable(i_res_count) && $stable(i_res_last), "result changed while stalled")
endmodule

bind tga_pixel_stream_decoder_unit tgad_checker u_tgad_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_argb  (o_res.pixel_argb),
    .i_res_count (o_res.repeat_count),
    .i_res_last  (o_res.last_of_image)
);

[dv/tga_decode_checker.sv]
// Checker for the TGA pixel decoder: predicts every decoded pixel and compares it with o_res.
module tga_decode_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    tgad_cfg_if  i_cfg,
    tgad_in_if   i_pix,
    tgad_out_if  i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);
    import tgad_pkg::*;

    typedef struct packed {
        logic [31:0] argb;
        logic [7:0]  repeat_count;
        logic        last_of_image;
    } t_pixel;

    // Colour map copy: only entries the stimulus has loaded are ever read
    logic [31:0] colour_map [256];

    // Decoder state
    logic [23:0] gathered      = '0;
    logic [1:0]  gathered_n    = '0;
    logic [7:0]  packet_left   = '0;
    logic        run_packet    = 1'b0;
    logic [24:0] image_left    = RST_PIXEL_COUNT;

    // Register copies
    logic [1:0]  kind_reg        = RST_IMAGE_KIND;
    logic [2:0]  pix_bytes_reg   = RST_PIXEL_BYTES;
    logic [2:0]  entry_bytes_reg = RST_MAP_ENTRY_BYTES;
    logic [24:0] count_reg       = RST_PIXEL_COUNT;

    t_pixel expected_pixels [$];
    int     fails   = 0;
    int     checked = 0;

    // Byte counts outside 2..4 act as the nearest end
    function automatic logic [2:0] bytes_in_range(input logic [2:0] n);
        if (n < 3'd2) return 3'd2;
        if (n > 3'd4) return 3'd4;
        return n;
    endfunction

    // 5-bit channel to 8 bits by replicating the top bits
    function automatic logic [7:0] stretch5(input logic [4:0] c);
        logic [7:0] x;
        x = {3'b000, c};
        return (x << 3) | (x >> 2);
    endfunction

    // Little-endian raw word of n bytes to ARGB
    function automatic logic [31:0] word_to_argb(input logic [31:0] w, input logic [2:0] n);
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [31:0] argb;
        lo = w[7:0];
        hi = w[15:8];
        case (n)
            3'd2: begin
                argb = {(hi[7] ? 8'hFF : 8'h00), stretch5(hi[6:2]),
                        stretch5({hi[1:0], lo[7:5]}), stretch5(lo[4:0])};
            end
            3'd3: begin
                argb = {8'hFF, w[23:0]};
            end
            default: begin
                argb = w;
            end
        endcase
        return argb;
    endfunction

    function automatic void restart_image();
        gathered    = '0;
        gathered_n  = '0;
        packet_left = '0;
        run_packet  = 1'b0;
        image_left  = (count_reg == '0) ? 25'd1 : count_reg;
    endfunction

    // Register write; indexes past the list leave everything alone
    function automatic void apply_register(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            CFG_IMAGE_KIND:      kind_reg        = data[1:0];
            CFG_PIXEL_BYTES:     pix_bytes_reg   = data[2:0];
            CFG_MAP_ENTRY_BYTES: entry_bytes_reg = data[2:0];
            CFG_PIXEL_COUNT:     count_reg       = data[24:0];
            default:             return;
        endcase
        restart_image();
    endfunction

    // One accepted request; returns 1 when it completes a pixel
    function automatic bit decode_request(input logic req_type, input logic [7:0] idx,
                                          input logic [31:0] entry, input logic [7:0] b,
                                          output t_pixel px);
        logic        mapped;
        logic        rle;
        logic [8:0]  len;
        logic [2:0]  need;
        logic [31:0] word;
        logic [31:0] argb;
        logic [7:0]  rep;
        px = '0;
        if (req_type == REQ_MAP_LOAD) begin
            colour_map[idx] = entry;
            return 1'b0;
        end
        mapped = !kind_reg[KIND_TRUECOLOR_BIT];
        rle    = kind_reg[KIND_RLE_BIT];

        // packet header: length clipped to what is left of the image
        if (rle && packet_left == 8'd0) begin
            len = {2'b00, b[6:0]} + 9'd1;
            if (25'(len) > image_left) len = image_left[8:0];
            packet_left = len[7:0];
            run_packet  = b[7];
            gathered    = '0;
            gathered_n  = '0;
            return 1'b0;
        end

        if (mapped) begin
            argb = word_to_argb(colour_map[b], bytes_in_range(entry_bytes_reg));
        end else begin
            need = bytes_in_range(pix_bytes_reg);
            if ({1'b0, gathered_n} + 3'd1 < need) begin
                gathered   = gathered | (24'(b) << (8 * gathered_n));
                gathered_n = gathered_n + 2'd1;
                return 1'b0;
            end
            word       = {8'h00, gathered} | (32'(b) << (8 * gathered_n));
            argb       = word_to_argb(word, need);
            gathered   = '0;
            gathered_n = '0;
        end

        if (rle && run_packet) begin
            rep         = packet_left;
            packet_left = 8'd0;
        end else begin
            rep = 8'd1;
            if (rle) packet_left = packet_left - 8'd1;
        end
        if (25'(rep) > image_left) rep = image_left[7:0];
        if (rep == 8'd0) rep = 8'd1;
        image_left = image_left - 25'(rep);

        px.argb          = argb;
        px.repeat_count  = rep;
        px.last_of_image = (image_left == '0);
        if (image_left == '0) restart_image();
        return 1'b1;
    endfunction

    // Sample all three channels at the edge; results first, as none comes from this edge's input
    always @(posedge i_clk) begin
        t_pixel got;
        t_pixel want;
        t_pixel px;
        if (!i_rst_n) begin
            kind_reg        = RST_IMAGE_KIND;
            pix_bytes_reg   = RST_PIXEL_BYTES;
            entry_bytes_reg = RST_MAP_ENTRY_BYTES;
            count_reg       = RST_PIXEL_COUNT;
            restart_image();
            expected_pixels.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got = '{i_res.pixel_argb, i_res.repeat_count, i_res.last_of_image};
                if (expected_pixels.size() == 0) begin
                    $error("unexpected pixel result: argb %h, repeat %0d, last %0d",
                           got.argb, got.repeat_count, got.last_of_image);
                    fails++;
                end else begin
                    want = expected_pixels.pop_front();
                    checked++;
                    if (got.argb !== want.argb) begin
                        $error("pixel_argb: expected %h, actual %h", want.argb, got.argb);
                        fails++;
                    end
                    if (got.repeat_count !== want.repeat_count) begin
                        $error("repeat_count: expected %0d, actual %0d",
                               want.repeat_count, got.repeat_count);
                        fails++;
                    end
                    if (got.last_of_image !== want.last_of_image) begin
                        $error("last_of_image: expected %0d, actual %0d",
                               want.last_of_image, got.last_of_image);
                        fails++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) apply_register(i_cfg.index, i_cfg.data);
            if (i_pix.valid && i_pix.ready) begin
                if (decode_request(i_pix.req_type, i_pix.map_index, i_pix.map_entry,
                                   i_pix.data_byte, px))
                    expected_pixels.push_back(px);
            end
        end
        o_pending    <= expected_pixels.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

[dv/tga_pixel_stream_decoder_unit_test.sv]
// Testbench top for the TGA pixel decoder: stimulus, receiver pacing and verdict.
module tga_pixel_stream_decoder_unit_test;
    import tgad_pkg::*;

    // image_kind codes
    localparam logic [1:0] KIND_MAPPED_RAW = 2'd0;
    localparam logic [1:0] KIND_TRUE_RAW   = 2'd1;
    localparam logic [1:0] KIND_MAPPED_RLE = 2'd2;
    localparam logic [1:0] KIND_TRUE_RLE   = 2'd3;

    // Register index past the end of the list
    localparam logic [2:0] CFG_SPARE_INDEX = 3'd7;

    localparam int RANDOM_REQUESTS  = 494;
    localparam int CALM_TAIL        = 100;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES    = 4;
    localparam int DRAIN_LIMIT      = 20000;
    localparam int CLK_PERIOD       = 8;

    logic i_clk;
    logic i_rst_n;

    tgad_cfg_if cfg_bus ();
    tgad_in_if  pix_bus ();
    tgad_out_if res_bus ();

    int fail_count;
    int pending;
    int checked;

    bit calm           = 1'b0;
    bit sender_idles   = 1'b1;
    bit long_hold_req  = 1'b0;
    bit long_hold_done = 1'b0;
    int requests_sent  = 0;
    int loads_sent     = 0;
    int settings_used  = 0;

    tga_pixel_stream_decoder_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_pix   (pix_bus),
        .o_res   (res_bus)
    );

    tga_decode_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_bus),
        .i_pix        (pix_bus),
        .i_res        (res_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Reset, once
    initial begin
        i_rst_n <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Run limit
    initial begin
        #(CLK_PERIOD * 200000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: random hold-off bursts, one long hold-off, none in the tail
    initial begin
        int n;
        res_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (long_hold_req && !long_hold_done) begin
                res_bus.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                long_hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 4);
                res_bus.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                res_bus.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Some register writes carry junk above the register width
    function automatic logic [31:0] with_noise(input logic [31:0] value, input int width);
        if ($urandom_range(0, 3) == 0) return value | ($urandom << width);
        return value;
    endfunction

    // Stop offering requests and wait until every predicted pixel is out
    task automatic drain_to_idle();
        pix_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Caller lowers valid after the last write of a batch
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
    endtask

    task automatic apply_settings(input logic [31:0] kind, input logic [31:0] pix_bytes,
                                  input logic [31:0] entry_bytes, input logic [31:0] count);
        drain_to_idle();
        write_reg(CFG_IMAGE_KIND, kind);
        write_reg(CFG_PIXEL_BYTES, pix_bytes);
        write_reg(CFG_MAP_ENTRY_BYTES, entry_bytes);
        write_reg(CFG_PIXEL_COUNT, count);
        cfg_bus.valid <= 1'b0;
        settings_used++;
    endtask

    // One request on i_pix, with an optional idle burst in front
    task automatic send_request(input logic req_type, input logic [7:0] idx,
                                input logic [31:0] entry, input logic [7:0] b);
        int gap;
        if (!calm && sender_idles && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            pix_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_bus.valid     <= 1'b1;
        pix_bus.req_type  <= req_type;
        pix_bus.map_index <= idx;
        pix_bus.map_entry <= entry;
        pix_bus.data_byte <= b;
        do @(posedge i_clk); while (!pix_bus.ready);
        requests_sent++;
        if (req_type == REQ_MAP_LOAD) loads_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_request(REQ_DATA_BYTE, 8'($urandom), $urandom, b);
    endtask

    task automatic send_load(input logic [7:0] idx, input logic [31:0] entry);
        send_request(REQ_MAP_LOAD, idx, entry, 8'($urandom));
    endtask

    // Stimulus
    initial begin
        int          random_done;
        int          epoch;
        int          burst;
        int          waited;
        int          r;
        logic [1:0]  kind;
        logic [2:0]  pb;
        logic [2:0]  mb;
        logic [24:0] pc;
        logic [31:0] entry;
        logic [7:0]  b;

        pix_bus.valid     <= 1'b0;
        pix_bus.req_type  <= REQ_DATA_BYTE;
        pix_bus.map_index <= '0;
        pix_bus.map_entry <= '0;
        pix_bus.data_byte <= '0;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.index     <= CFG_IMAGE_KIND;
        cfg_bus.data      <= '0;

        do @(posedge i_clk); while (!i_rst_n);

        // Fill the whole colour map so every index byte reads a loaded entry
        for (int i = 0; i < 256; i++) begin
            case (i)
                0:       entry = 32'h0000_0000;
                1:       entry = 32'h0000_8000;  // 16-bit: attribute bit only
                2:       entry = 32'h0000_7FFF;  // 16-bit: all colour, no alpha
                255:     entry = 32'hFFFF_FFFF;
                default: entry = $urandom;
            endcase
            send_load(8'(i), entry);
        end

        // 16-bit truecolor: alpha bit alone, then every colour bit
        apply_settings(32'(KIND_TRUE_RAW), 2, 3, 32'(RST_PIXEL_COUNT));
        send_byte(8'h00); send_byte(8'h80);
        send_byte(8'hFF); send_byte(8'h7F);

        // 24-bit truecolor takes opaque alpha
        apply_settings(32'(KIND_TRUE_RAW), 3, 3, 32'(RST_PIXEL_COUNT));
        send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);

        // Longest run clipped at the end of a three-pixel image
        apply_settings(32'(KIND_TRUE_RLE), 4, 3, 3);
        send_byte(8'hFF);
        send_byte(8'h00); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);

        // Zero pixel count acts as one: every pixel ends the image
        apply_settings(32'(KIND_MAPPED_RAW), 4, 2, 0);
        send_byte(8'h01); send_byte(8'h02);

        // Mapped run-length; a write to a spare index inside a packet must not restart it
        apply_settings(32'(KIND_MAPPED_RLE), 4, 4, 200);
        send_byte(8'h81);
        drain_to_idle();
        write_reg(CFG_SPARE_INDEX, $urandom);
        cfg_bus.valid <= 1'b0;
        send_byte(8'hFF);
        send_byte(8'h01); send_byte(8'h00); send_byte(8'hFF);

        // Long receiver hold-off while 16-bit pixels keep coming
        apply_settings(32'(KIND_TRUE_RAW), 2, 3, 5000);
        long_hold_req = 1'b1;
        for (int i = 0; i < 80; i++) send_byte(8'($urandom));

        // Random settings, each followed by a burst of random requests
        random_done = 0;
        epoch       = 0;
        while (random_done < RANDOM_REQUESTS) begin
            kind = 2'($urandom_range(0, 3));
            pb   = ($urandom_range(0, 4) != 0) ? 3'($urandom_range(2, 4))
                                               : 3'($urandom_range(0, 7));
            mb   = ($urandom_range(0, 4) != 0) ? 3'($urandom_range(2, 4))
                                               : 3'($urandom_range(0, 7));
            r = $urandom_range(0, 99);
            if (r < 5)       pc = '0;
            else if (r < 60) pc = 25'($urandom_range(1, 40));
            else if (r < 90) pc = 25'($urandom_range(41, 400));
            else if (r < 95) pc = 25'h100_0000;
            else             pc = 25'h1FF_FFFF;
            // the first two settings take the extremes of the byte counts and pixel count
            if (epoch == 0) begin
                pb = 3'd7;
                mb = 3'd0;
                pc = 25'h1FF_FFFF;
            end else if (epoch == 1) begin
                pb = 3'd1;
                mb = 3'd5;
                pc = 25'h100_0000;
            end
            apply_settings(with_noise(32'(kind), 2), with_noise(32'(pb), 3),
                           with_noise(32'(mb), 3), with_noise(32'(pc), 25));
            sender_idles = ($urandom_range(0, 3) != 0);
            burst = $urandom_range(20, 90);
            for (int j = 0; j < burst && random_done < RANDOM_REQUESTS; j++) begin
                calm = (random_done >= RANDOM_REQUESTS - CALM_TAIL);
                if ($urandom_range(0, 99) < 8) begin
                    send_load(8'($urandom), $urandom);
                end else begin
                    case ($urandom_range(0, 9))
                        0:       b = 8'h00;
                        1:       b = 8'hFF;
                        2:       b = 8'h7F;
                        3:       b = 8'h80;
                        default: b = 8'($urandom);
                    endcase
                    send_byte(b);
                end
                random_done++;
            end
            epoch++;
        end

        // Drain, then allow the pipeline latency
        pix_bus.valid <= 1'b0;
        calm = 1'b1;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (pending != 0 && waited < DRAIN_LIMIT);
        repeat (8) @(posedge i_clk);
        if (pending != 0) $error("%0d predicted pixel results never came out", pending);

        $display("Sent %0d requests (%0d colour-map loads) over %0d register settings",
                 requests_sent, loads_sent, settings_used);
        $display("Compared %0d pixel results; receiver held off once for %0d cycles",
                 checked, LONG_HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
